// File: design/assert_macros.svh
// Assertion macros shared by the escape decoder modules.
// Each macro expects aclk and aresetn to be visible in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset
`define ESD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset
`define ESD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must never hold
`define ESD_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

// File: design/esd_pkg.sv
// Shared types and constants for the escape sequence decoder.
// No dependencies; imported by the front, queue, back and top modules.
package esd_pkg;

    // Parser modes
    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_ESC  = 3'd1;
    localparam logic [2:0] MODE_OCT  = 3'd2;
    localparam logic [2:0] MODE_HEX  = 3'd3;
    localparam logic [2:0] MODE_DEC  = 3'd4;

    // Characters recognized after a backslash (upper case form)
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_X      = 8'h58;

    // Control codes produced by the letter escapes
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_ESC = 8'h1B;

    // Third-digit limits: octal value, decimal value and its tight case
    localparam logic [7:0] OCT_LIMIT    = 8'd31;
    localparam logic [7:0] DEC_LIMIT_HI = 8'd25;
    localparam logic [7:0] DEC_LIMIT_LO = 8'd24;
    localparam logic [3:0] DEC_TOP_DIGIT = 4'd5;

    // One queued job: zero to two decoded bytes for one input character
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] b0;
        logic [7:0] b1;
    } esd_entry_t;

endpackage

// File: design/esd_front.sv
// Front end: accepts characters, runs the escape parser, queues decoded bytes.
// Depends on esd_pkg.
module esd_front
    import esd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_char,
    input  logic       s_end_of_text,
    input  logic       q_full,
    output logic       q_push,
    output esd_entry_t q_entry
);

    logic [2:0] mode_reg, mode_next;
    logic [7:0] acc_reg, acc_next;
    logic [1:0] cnt_reg, cnt_next;

    logic       accept;
    logic [7:0] up_char;
    logic       is_oct, is_dec, is_hex;
    logic [3:0] dec_val, hex_val;
    logic [2:0] cnt_inc;
    logic [7:0] dec_prod;
    logic       dec_third_ok;
    esd_entry_t ent;

    // Append one byte to a job, keeping at most two
    function automatic esd_entry_t add_byte(esd_entry_t e, logic [7:0] b);
        esd_entry_t r;
        r = e;
        if (e.count == 2'd0) begin
            r.b0    = b;
            r.count = 2'd1;
        end else if (e.count == 2'd1) begin
            r.b1    = b;
            r.count = 2'd2;
        end
        return r;
    endfunction

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Classify the character
    assign up_char = (s_in_char >= 8'h61 && s_in_char <= 8'h7A) ?
                     (s_in_char & 8'hDF) : s_in_char;
    assign is_oct  = (s_in_char >= 8'h30) && (s_in_char <= 8'h37);
    assign is_dec  = (s_in_char >= 8'h30) && (s_in_char <= 8'h39);
    assign is_hex  = is_dec || (up_char >= 8'h41 && up_char <= 8'h46);
    assign dec_val = s_in_char[3:0];
    assign hex_val = is_dec ? s_in_char[3:0] : 4'(s_in_char[3:0] + 4'd9);
    assign cnt_inc = {1'b0, cnt_reg} + 3'd1;
    assign dec_prod = 8'({acc_reg, 3'b000} + {acc_reg, 1'b0} + {4'b0000, dec_val});
    assign dec_third_ok = (cnt_reg < 2'd2) ||
                          ((acc_reg <= DEC_LIMIT_HI) &&
                           ((dec_val <= DEC_TOP_DIGIT) || (acc_reg <= DEC_LIMIT_LO)));

    // Parser next state and bytes produced by this character
    always_comb begin
        ent       = '0;
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        case (mode_reg)
            MODE_ESC: begin
                mode_next = MODE_IDLE;
                acc_next  = 8'd0;
                cnt_next  = 2'd0;
                case (up_char)
                    CH_BSLASH: ent = add_byte(ent, CH_BSLASH);
                    CH_B:      ent = add_byte(ent, CODE_BS);
                    CH_F:      ent = add_byte(ent, CODE_FF);
                    CH_N:      ent = add_byte(ent, CODE_LF);
                    CH_R:      ent = add_byte(ent, CODE_CR);
                    CH_T:      ent = add_byte(ent, CODE_TAB);
                    CH_E:      ent = add_byte(ent, CODE_ESC);
                    CH_ZERO:   mode_next = MODE_OCT;
                    CH_X:      mode_next = MODE_HEX;
                    default: begin
                        if (is_dec) begin
                            mode_next = MODE_DEC;
                            acc_next  = {4'b0000, dec_val};
                            cnt_next  = 2'd1;
                        end else begin
                            ent = add_byte(ent, s_in_char);
                        end
                    end
                endcase
            end
            MODE_OCT: begin
                if (is_oct && ((cnt_reg < 2'd2) || (acc_reg <= OCT_LIMIT))) begin
                    acc_next = {acc_reg[4:0], s_in_char[2:0]};
                    cnt_next = cnt_inc[1:0];
                    if (cnt_inc >= 3'd3) begin
                        ent       = add_byte(ent, acc_next);
                        mode_next = MODE_IDLE;
                        acc_next  = 8'd0;
                        cnt_next  = 2'd0;
                    end
                end else begin
                    ent       = add_byte(ent, acc_reg);
                    mode_next = MODE_IDLE;
                    acc_next  = 8'd0;
                    cnt_next  = 2'd0;
                    if (s_in_char == CH_BSLASH) mode_next = MODE_ESC;
                    else ent = add_byte(ent, s_in_char);
                end
            end
            MODE_HEX: begin
                if (is_hex && (cnt_reg < 2'd2)) begin
                    acc_next = {acc_reg[3:0], hex_val};
                    cnt_next = cnt_inc[1:0];
                    if (cnt_inc >= 3'd2) begin
                        ent       = add_byte(ent, acc_next);
                        mode_next = MODE_IDLE;
                        acc_next  = 8'd0;
                        cnt_next  = 2'd0;
                    end
                end else begin
                    ent       = add_byte(ent, acc_reg);
                    mode_next = MODE_IDLE;
                    acc_next  = 8'd0;
                    cnt_next  = 2'd0;
                    if (s_in_char == CH_BSLASH) mode_next = MODE_ESC;
                    else ent = add_byte(ent, s_in_char);
                end
            end
            MODE_DEC: begin
                if (is_dec && dec_third_ok) begin
                    acc_next = dec_prod;
                    cnt_next = cnt_inc[1:0];
                    if (cnt_inc >= 3'd3) begin
                        ent       = add_byte(ent, acc_next);
                        mode_next = MODE_IDLE;
                        acc_next  = 8'd0;
                        cnt_next  = 2'd0;
                    end
                end else begin
                    ent       = add_byte(ent, acc_reg);
                    mode_next = MODE_IDLE;
                    acc_next  = 8'd0;
                    cnt_next  = 2'd0;
                    if (s_in_char == CH_BSLASH) mode_next = MODE_ESC;
                    else ent = add_byte(ent, s_in_char);
                end
            end
            default: begin
                // Idle and unused codes: plain character
                mode_next = MODE_IDLE;
                acc_next  = 8'd0;
                cnt_next  = 2'd0;
                if (s_in_char == CH_BSLASH) mode_next = MODE_ESC;
                else ent = add_byte(ent, s_in_char);
            end
        endcase

        // Flush anything pending on the final character
        if (s_end_of_text && (mode_next != MODE_IDLE)) begin
            ent       = add_byte(ent, (mode_next == MODE_ESC) ? 8'd0 : acc_next);
            mode_next = MODE_IDLE;
            acc_next  = 8'd0;
            cnt_next  = 2'd0;
        end
    end

    assign q_entry = ent;
    assign q_push  = accept && (ent.count != 2'd0);

    // Advance parser state on each transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= 8'd0;
            cnt_reg  <= 2'd0;
        end else if (accept) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// File: design/esd_queue.sv
// Short job queue between the parser front end and the output back end.
// Depends on esd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module esd_queue
    import esd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  esd_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output esd_entry_t pop_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    esd_entry_t       slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = slots_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + CNT_W'(1);
        else if (!push && pop) count_next = count_reg - CNT_W'(1);
    end

    // Store incoming jobs
    always_ff @(posedge aclk) begin
        if (push) slots_reg[wr_ptr_reg] <= push_entry;
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    `ESD_ASSERT_NEVER(a_no_push_full, push && full, "push into full queue")
    `ESD_ASSERT_NEVER(a_no_pop_empty, pop && !not_empty, "pop from empty queue")
    `ESD_ASSERT_IMP(a_ptr_match, (count_reg == '0) || full, wr_ptr_reg == rd_ptr_reg,
        "queue pointers disagree with occupancy")

endmodule

// File: design/esd_back.sv
// Back end: takes queued jobs and delivers their bytes one per transfer.
// Depends on esd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module esd_back
    import esd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  esd_entry_t q_entry,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last
);

    esd_entry_t ent_reg;
    logic       valid_reg;
    logic       idx_reg;
    logic       out_done;
    logic       is_last;

    assign out_done = valid_reg && m_ready;
    assign is_last  = idx_reg || (ent_reg.count == 2'd1);
    assign q_pop    = q_valid && (!valid_reg || (out_done && is_last));

    assign m_valid    = valid_reg;
    assign m_out_byte = idx_reg ? ent_reg.b1 : ent_reg.b0;
    assign m_run_last = is_last;

    // Hold the current job
    always_ff @(posedge aclk) begin
        if (q_pop) ent_reg <= q_entry;
    end

    // Step through the bytes of the current job
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
            idx_reg   <= 1'b0;
        end else if (out_done) begin
            if (is_last) valid_reg <= 1'b0;
            else idx_reg <= 1'b1;
        end
    end

    `ESD_ASSERT_IMP(a_job_nonempty, valid_reg, (ent_reg.count == 2'd1) || (ent_reg.count == 2'd2),
        "output job holds no bytes")
    `ESD_ASSERT_NXT(a_second_byte, out_done && !is_last, valid_reg && idx_reg && m_run_last,
        "second byte of a job not presented")

endmodule

// File: design/escape_sequence_decoder.sv
// Backslash escape decoder, top level: front parser, job queue, output stage.
// Depends on esd_pkg, esd_front, esd_queue and esd_back.
//
// Usage:
//   Input channel s_valid/s_ready carries one character (s_in_char) and a
//   final-character flag (s_end_of_text). Output channel m_valid/m_ready
//   carries one decoded byte (m_out_byte) with m_run_last set on the last
//   byte caused by a given character. A character may cause zero, one or
//   two bytes; characters that cause none produce no transfer.
// Path: a byte is written into the job queue at its character's transfer and,
//   when the queue and output stage are empty, is then loaded into the
//   output register that drives m_out_byte and m_valid.
// Throughput: one character per cycle while s_ready is high; the output stage
//   sends one byte per cycle while m_ready is high, so a character
//   that yields two bytes holds it for both. The job queue (QUEUE_DEPTH entries) absorbs the difference.
// Stall: when m_ready is low the output byte holds; the queue fills and
//   s_ready drops only once all QUEUE_DEPTH entries are taken.
// Reset: aresetn low (synchronous) returns the parser to idle, empties the
//   queue and clears m_valid.
module escape_sequence_decoder
    import esd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_char,
    input  logic       s_end_of_text,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last
);

    esd_entry_t push_entry, pop_entry;
    logic       push, pop, full, not_empty;

    esd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_char     (s_in_char),
        .s_end_of_text (s_end_of_text),
        .q_full        (full),
        .q_push        (push),
        .q_entry       (push_entry)
    );

    esd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .not_empty  (not_empty),
        .pop_entry  (pop_entry)
    );

    esd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (not_empty),
        .q_entry    (pop_entry),
        .q_pop      (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_last (m_run_last)
    );

endmodule
